>>> src/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef logic signed [DATA_W-1:0] data_t;

endpackage
`default_nettype wire

>>> src/fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Signed Q-format ALU: add, subtract, multiply, divide with compare flags.
// Depends on fpa_pkg.
// W = min(INT_BITS + FRAC_BITS, 32). Throughput: one transfer per cycle unless
// rsp_ready stalls the output; the divider is a restoring array with one quotient
// bit per stage, so every command walks the same W + FRAC_BITS stages.
// Reset clears all valid bits; data registers are not reset.
module fixed_point_alu #(
	parameter int unsigned INT_BITS  = 16,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  fpa_pkg::cmd_t       command,
	input  fpa_pkg::data_t      operand_a,
	input  fpa_pkg::data_t      operand_b,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output fpa_pkg::data_t      result_value,
	output logic                a_less_than_b,
	output logic                a_equals_b,
	output logic                divide_by_zero
);
	import fpa_pkg::*;

	localparam int W     = (INT_BITS + FRAC_BITS > DATA_W) ? DATA_W
	                                                         : int'(INT_BITS + FRAC_BITS);
	localparam int SH    = DATA_W - W;
	localparam int NSTEP = W + int'(FRAC_BITS);

	logic en;
	logic load_s1;

	// stage 1: operand capture, sign-extended from W bits
	logic  v_s1;
	cmd_t  cmd_s1;
	data_t a_s1, b_s1;
	data_t a_sh, b_sh;

	assign en        = !rsp_valid || rsp_ready;
	assign load_s1   = en || !v_s1;
	assign req_ready = load_s1;

	assign a_sh = operand_a <<< SH;
	assign b_sh = operand_b <<< SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1 <= command;
			a_s1   <= a_sh >>> SH;
			b_s1   <= b_sh >>> SH;
		end
	end

	// stage 2: multiply, add/sub, flags, magnitudes
	logic                       v_s2;
	cmd_t                       cmd_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	data_t                      addsub_s2;
	logic                       lt_s2, eq_s2, dz_s2, neg_s2;
	logic [DATA_W-1:0]          den_s2;
	logic [W-1:0]               num_s2;
	logic [DATA_W-1:0]          abs_a, abs_b;

	assign abs_a = a_s1[DATA_W-1] ? DATA_W'(-a_s1) : DATA_W'(a_s1);
	assign abs_b = b_s1[DATA_W-1] ? DATA_W'(-b_s1) : DATA_W'(b_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2    <= cmd_s1;
			prod_s2   <= a_s1 * b_s1;
			addsub_s2 <= (cmd_s1 == CMD_SUB) ? a_s1 - b_s1 : a_s1 + b_s1;
			lt_s2     <= a_s1 < b_s1;
			eq_s2     <= a_s1 == b_s1;
			dz_s2     <= (cmd_s1 == CMD_DIV) && (b_s1 == '0);
			neg_s2    <= a_s1[DATA_W-1] ^ b_s1[DATA_W-1];
			den_s2    <= abs_b;
			num_s2    <= abs_a[W-1:0];
		end
	end

	// stage 3: restoring divider, one quotient bit per step
	logic              v_s3   [NSTEP];
	cmd_t              cmd_s3 [NSTEP];
	data_t             res_s3 [NSTEP];
	logic              lt_s3  [NSTEP];
	logic              eq_s3  [NSTEP];
	logic              dz_s3  [NSTEP];
	logic              neg_s3 [NSTEP];
	logic [DATA_W-1:0] den_s3 [NSTEP];
	logic [W-1:0]      num_s3 [NSTEP];
	logic [DATA_W-1:0] rem_s3 [NSTEP];
	logic [W-1:0]      q_s3   [NSTEP];

	logic signed [2*DATA_W-1:0] prod_shr;
	assign prod_shr = prod_s2 >>> FRAC_BITS;

	for (genvar k = 0; k < NSTEP; k++) begin : g_div
		logic              v_in;
		cmd_t              cmd_in;
		data_t             res_in;
		logic              lt_in, eq_in, dz_in, neg_in;
		logic [DATA_W-1:0] den_in;
		logic [W-1:0]      num_in;
		logic [DATA_W-1:0] rem_in;
		logic [W-1:0]      q_in;
		logic              nb;
		logic [DATA_W:0]   trial;
		logic              ge;
		logic [W:0]        q_ext;

		if (k == 0) begin : g_first
			assign v_in   = v_s2;
			assign cmd_in = cmd_s2;
			assign res_in = (cmd_s2 == CMD_MUL) ? prod_shr[DATA_W-1:0] : addsub_s2;
			assign lt_in  = lt_s2;
			assign eq_in  = eq_s2;
			assign dz_in  = dz_s2;
			assign neg_in = neg_s2;
			assign den_in = den_s2;
			assign num_in = num_s2;
			assign rem_in = '0;
			assign q_in   = '0;
		end else begin : g_next
			assign v_in   = v_s3[k-1];
			assign cmd_in = cmd_s3[k-1];
			assign res_in = res_s3[k-1];
			assign lt_in  = lt_s3[k-1];
			assign eq_in  = eq_s3[k-1];
			assign dz_in  = dz_s3[k-1];
			assign neg_in = neg_s3[k-1];
			assign den_in = den_s3[k-1];
			assign num_in = num_s3[k-1];
			assign rem_in = rem_s3[k-1];
			assign q_in   = q_s3[k-1];
		end

		if (k < W) begin : g_num_bit
			assign nb = num_in[W-1-k];
		end else begin : g_zero_bit
			assign nb = 1'b0;
		end

		assign trial = {rem_in, nb};
		assign ge    = trial >= {1'b0, den_in};
		assign q_ext = {q_in, ge};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k] <= 1'b0;
			end else if (en) begin
				v_s3[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cmd_s3[k] <= cmd_in;
				res_s3[k] <= res_in;
				lt_s3[k]  <= lt_in;
				eq_s3[k]  <= eq_in;
				dz_s3[k]  <= dz_in;
				neg_s3[k] <= neg_in;
				den_s3[k] <= den_in;
				num_s3[k] <= num_in;
				rem_s3[k] <= ge ? DATA_W'(trial - {1'b0, den_in}) : trial[DATA_W-1:0];
				q_s3[k]   <= q_ext[W-1:0];
			end
		end
	end

	// stage 4: result select, wrap to W bits, output register
	logic [W-1:0] q_last;
	data_t        res_sel;
	data_t        res_wrap;

	assign q_last = neg_s3[NSTEP-1] ? W'(-q_s3[NSTEP-1]) : q_s3[NSTEP-1];

	always_comb begin
		case (cmd_s3[NSTEP-1])
			CMD_DIV: begin
				res_sel = dz_s3[NSTEP-1] ? '0 : DATA_W'(q_last);
			end
			default: begin
				res_sel = res_s3[NSTEP-1];
			end
		endcase
	end

	assign res_wrap = res_sel <<< SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= v_s3[NSTEP-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_value   <= res_wrap >>> SH;
			a_less_than_b  <= lt_s3[NSTEP-1];
			a_equals_b     <= eq_s3[NSTEP-1];
			divide_by_zero <= dz_s3[NSTEP-1];
		end
	end

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fixed_point_alu: directed corner operands, then
// randomized bursty traffic against a Q-format result predictor.
// Depends on fpa_pkg and fixed_point_alu.
module tb;
	import fpa_pkg::*;

	localparam int unsigned INT_W  = 16;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned OP_W   = (INT_W + FRAC_W > 32) ? 32 :
		((INT_W + FRAC_W < 1) ? 1 : INT_W + FRAC_W);
	localparam int unsigned PIPE_DEPTH   = OP_W + FRAC_W + 3;
	localparam int unsigned SETTLE_TICKS = 2 * PIPE_DEPTH + 20;
	localparam int          RANDOM_ITEMS = 1650;
	localparam data_t       MAX_Q = 32'sh7FFF_FFFF;
	localparam data_t       MIN_Q = 32'sh8000_0000;
	localparam data_t       ONE_Q = 32'sh0001_0000;

	typedef struct {
		data_t value;
		logic  lt;
		logic  eq;
		logic  dz;
	} alu_result_t;

	class alu_result_book;
		alu_result_t pending[$];
		int unsigned mismatches;
		int unsigned checked;

		function longint sext(longint v, int unsigned w);
			logic [63:0] m;
			m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
			v = v & m;
			if (v[w-1])
				v = v | ~m;
			return v;
		endfunction

		function alu_result_t predict_result(cmd_t cmd, data_t a_in, data_t b_in);
			alu_result_t r;
			longint a;
			longint b;
			longint raw;
			a = sext(longint'(a_in), OP_W);
			b = sext(longint'(b_in), OP_W);
			raw = 0;
			r.dz = 1'b0;
			case (cmd)
				CMD_ADD: raw = a + b;
				CMD_SUB: raw = a - b;
				CMD_MUL: raw = (a * b) >>> FRAC_W;
				CMD_DIV: begin
					if (b == 0)
						r.dz = 1'b1;
					else
						raw = (a * (longint'(1) <<< FRAC_W)) / b;
				end
				default: raw = 0;
			endcase
			r.value = data_t'(sext(raw, OP_W));
			r.lt = (a < b);
			r.eq = (a == b);
			return r;
		endfunction

		function void note_request(cmd_t cmd, data_t a, data_t b);
			pending.push_back(predict_result(cmd, a, b));
		endfunction

		function void check_response(data_t value, logic lt, logic eq, logic dz);
			alu_result_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("result with nothing outstanding: value %0d", value);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			if (value !== e.value) begin
				$error("result_value: expected %0d, got %0d", e.value, value);
				mismatches++;
			end
			if (lt !== e.lt) begin
				$error("a_less_than_b: expected %0b, got %0b", e.lt, lt);
				mismatches++;
			end
			if (eq !== e.eq) begin
				$error("a_equals_b: expected %0b, got %0b", e.eq, eq);
				mismatches++;
			end
			if (dz !== e.dz) begin
				$error("divide_by_zero: expected %0b, got %0b", e.dz, dz);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	cmd_t  command = CMD_ADD;
	data_t operand_a = '0;
	data_t operand_b = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	data_t result_value;
	logic  a_less_than_b;
	logic  a_equals_b;
	logic  divide_by_zero;

	alu_result_book book = new();
	int unsigned cmd_count[4];
	int unsigned zero_div_count;
	int unsigned burst_left;
	int unsigned ready_mode;
	int unsigned ready_span;
	int unsigned tick;

	fixed_point_alu #(
		.INT_BITS(INT_W),
		.FRAC_BITS(FRAC_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.command(command),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.result_value(result_value),
		.a_less_than_b(a_less_than_b),
		.a_equals_b(a_equals_b),
		.divide_by_zero(divide_by_zero)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			book.note_request(command, operand_a, operand_b);
			cmd_count[command]++;
			if (command == CMD_DIV && operand_b == 0)
				zero_div_count++;
		end
		if (arst_n && rsp_valid && rsp_ready)
			book.check_response(result_value, a_less_than_b, a_equals_b, divide_by_zero);
	end

	// receiver backpressure: modes held for random spans
	always @(negedge clk) begin
		tick++;
		if (ready_span == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_span = $urandom_range(20, 300);
		end else begin
			ready_span--;
		end
		case (ready_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			2: rsp_ready <= (tick % 7) >= 3;
			default: rsp_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	task automatic send_item(cmd_t c, data_t a, data_t b);
		int unsigned gap;
		@(negedge clk);
		req_valid <= 1'b1;
		command <= c;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!req_ready);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) :
				$urandom_range(1, 40);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (book.outstanding() != 0) @(posedge clk);
	endtask

	function automatic data_t pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return data_t'($urandom);
			4, 5: return data_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			6: begin
				case ($urandom_range(0, 6))
					0: return '0;
					1: return data_t'(1);
					2: return data_t'(-1);
					3: return MAX_Q;
					4: return MIN_Q;
					5: return ONE_Q;
					default: return -ONE_Q;
				endcase
			end
			7: return $urandom_range(0, 1) ? data_t'($urandom_range(0, 65535)) :
				-data_t'($urandom_range(0, 65535));
			default: return data_t'($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	initial begin
		#8_000_000;
		$display("** fixed_point_alu: FAILED **");
		$finish;
	end

	initial begin
		data_t a;
		data_t b;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		send_item(CMD_ADD, '0, '0);
		send_item(CMD_ADD, MAX_Q, data_t'(1));
		send_item(CMD_ADD, MIN_Q, MIN_Q);
		send_item(CMD_ADD, data_t'(-1), '0);
		send_item(CMD_SUB, MIN_Q, data_t'(1));
		send_item(CMD_SUB, '0, MIN_Q);
		send_item(CMD_SUB, MAX_Q, data_t'(-1));
		send_item(CMD_SUB, data_t'(-5), data_t'(-5));
		send_item(CMD_MUL, ONE_Q, ONE_Q);
		send_item(CMD_MUL, MAX_Q, MAX_Q);
		send_item(CMD_MUL, MIN_Q, MIN_Q);
		send_item(CMD_MUL, MIN_Q, MAX_Q);
		send_item(CMD_MUL, data_t'(-1), data_t'(1));
		send_item(CMD_MUL, -3 * ONE_Q, data_t'(32768));
		send_item(CMD_DIV, ONE_Q, '0);
		send_item(CMD_DIV, '0, '0);
		send_item(CMD_DIV, MIN_Q, data_t'(-1));
		send_item(CMD_DIV, MIN_Q, data_t'(1));
		send_item(CMD_DIV, -ONE_Q, 3 * ONE_Q);
		send_item(CMD_DIV, data_t'(1), MAX_Q);
		send_item(CMD_DIV, MAX_Q, MIN_Q);
		send_item(CMD_DIV, data_t'(7), data_t'(-2));
		wait_all_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			a = pick_operand();
			case ($urandom_range(0, 19))
				0: b = '0;
				1: b = a;
				default: b = pick_operand();
			endcase
			send_item(cmd_t'($urandom_range(0, 3)), a, b);
			if (i == RANDOM_ITEMS / 2)
				wait_all_results();
		end

		wait_all_results();
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("Sent add %0d, sub %0d, mul %0d, div %0d (%0d by zero)",
			cmd_count[CMD_ADD], cmd_count[CMD_SUB], cmd_count[CMD_MUL],
			cmd_count[CMD_DIV], zero_div_count);
		$display("Checked %0d results under mixed backpressure, %0d mismatches",
			book.checked, book.mismatches);
		if (book.mismatches == 0 && book.outstanding() == 0)
			$display("** fixed_point_alu: PASSED **");
		else
			$display("** fixed_point_alu: FAILED **");
		$finish;
	end
endmodule
